### src/fgl_pkg.sv
// shared types and constants for the font glyph lookup block
package fgl_pkg;

    localparam int CODE_W   = 21;
    localparam int GLYPH_W  = 16;
    localparam int GBYTES_W = 13;
    localparam int ADDR_W   = 32;
    localparam int PROD_W   = GLYPH_W + GBYTES_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CODE_W-1:0] FALLBACK_CODE = CODE_W'(24'h00FFFD);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FONT_VALID    = 3'd0,
        CFG_TABLE_ENABLED = 3'd1,
        CFG_GLYPH_COUNT   = 3'd2,
        CFG_GLYPH_BYTES   = 3'd3,
        CFG_GLYPH_BASE    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic               table_enabled;
        logic [GLYPH_W-1:0] glyph_count;
    } scan_cfg_t;

    typedef struct packed {
        logic               done;
        logic [GLYPH_W-1:0] index;
    } scan_res_t;

endpackage

### src/fgl_table_ram.sv
// unicode table byte store with fill count and registered read port
module fgl_table_ram #(
    parameter int TABLE_BYTES = 16384
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clear,
    input  logic                               append,
    input  logic [7:0]                         wr_byte,
    input  logic [$clog2(TABLE_BYTES)-1:0]     rd_addr,
    output logic [7:0]                         rd_data,
    output logic [$clog2(TABLE_BYTES+1)-1:0]   map_length
);

    localparam int AW = $clog2(TABLE_BYTES);
    localparam int LW = $clog2(TABLE_BYTES + 1);

    logic [7:0]    mem [TABLE_BYTES];
    logic [LW-1:0] length_reg;
    logic [LW-1:0] length_next;
    logic          has_room;
    logic          wr_en;

    assign has_room = (length_reg < LW'(TABLE_BYTES));
    assign wr_en    = append && has_room;

    always_comb
    begin
        length_next = length_reg;
        if (clear)
        begin
            length_next = '0;
        end
        else if (wr_en)
        begin
            length_next = length_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else
        begin
            length_reg <= length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[length_reg[AW-1:0]] <= wr_byte;
        end
        rd_data <= mem[rd_addr];
    end

    assign map_length = length_reg;

endmodule

### src/fgl_scan.sv
// scan sequencer, one table byte per cycle between entry checks, shared compare
module fgl_scan #(
    parameter int TABLE_BYTES = 16384
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [fgl_pkg::CODE_W-1:0]          code,
    input  fgl_pkg::scan_cfg_t                  cfg,
    input  logic [$clog2(TABLE_BYTES+1)-1:0]    map_length,
    input  logic [7:0]                          rd_data,
    output logic [$clog2(TABLE_BYTES)-1:0]      rd_addr,
    output fgl_pkg::scan_res_t                  res
);

    import fgl_pkg::*;

    localparam int AW = $clog2(TABLE_BYTES);
    localparam int PW = $clog2(TABLE_BYTES + 4);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_START   = 6'b000010,
        S_CHECK   = 6'b000100,
        S_LEAD    = 6'b001000,
        S_CONT    = 6'b010000,
        S_RESOLVE = 6'b100000
    } scan_state_t;

    scan_state_t         state_reg, state_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       rp_reg, rp_next;
    logic [GLYPH_W-1:0]  glyph_reg, glyph_next;
    logic [GLYPH_W-1:0]  idx_reg, idx_next;
    logic [CODE_W-1:0]   val_reg, val_next;
    logic [1:0]          need_reg, need_next;

    logic [7:0]          cur_byte;
    logic [CODE_W-1:0]   cont_val;
    logic [CODE_W-1:0]   cmp_val;
    logic                cmp_match;
    logic [GLYPH_W-1:0]  direct_idx;
    logic                want_fallback;
    logic [PW-1:0]       len_ext;

    assign len_ext    = PW'(map_length);
    assign cur_byte   = (rp_reg < len_ext) ? rd_data : 8'h00;
    assign cont_val   = {val_reg[CODE_W-7:0], cur_byte[5:0]};
    assign cmp_val    = (state_reg == S_LEAD) ? CODE_W'(cur_byte) : cont_val;
    assign cmp_match  = (cmp_val == code_reg);
    assign direct_idx = (code_reg < CODE_W'(cfg.glyph_count)) ? code_reg[GLYPH_W-1:0] : '0;
    assign want_fallback = (idx_reg == '0) && (code_reg != '0) && (code_reg != FALLBACK_CODE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        pos_next   = pos_reg;
        rp_next    = rp_reg;
        glyph_next = glyph_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        need_next  = need_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    code_next  = code;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                pos_next   = '0;
                glyph_next = '0;
                if (cfg.table_enabled)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    idx_next   = direct_idx;
                    state_next = S_RESOLVE;
                end
            end
            S_CHECK:
            begin
                if (pos_reg >= len_ext)
                begin
                    idx_next   = direct_idx;
                    state_next = S_RESOLVE;
                end
                else if (glyph_reg >= cfg.glyph_count)
                begin
                    idx_next   = '0;
                    state_next = S_RESOLVE;
                end
                else
                begin
                    rp_next    = pos_reg;
                    state_next = S_LEAD;
                end
            end
            S_LEAD:
            begin
                unique casez (cur_byte)
                    8'b0???????:
                    begin
                        if (cmp_match)
                        begin
                            idx_next   = glyph_reg;
                            state_next = S_RESOLVE;
                        end
                        else
                        begin
                            pos_next   = pos_reg + PW'(1);
                            state_next = S_CHECK;
                        end
                    end
                    8'b110?????:
                    begin
                        val_next   = CODE_W'(cur_byte[4:0]);
                        need_next  = 2'd1;
                        rp_next    = rp_reg + PW'(1);
                        state_next = S_CONT;
                    end
                    8'b1110????:
                    begin
                        val_next   = CODE_W'(cur_byte[3:0]);
                        need_next  = 2'd2;
                        rp_next    = rp_reg + PW'(1);
                        state_next = S_CONT;
                    end
                    8'b11110???:
                    begin
                        val_next   = CODE_W'(cur_byte[2:0]);
                        need_next  = 2'd3;
                        rp_next    = rp_reg + PW'(1);
                        state_next = S_CONT;
                    end
                    8'b11111111:
                    begin
                        pos_next   = pos_reg + PW'(1);
                        glyph_next = glyph_reg + GLYPH_W'(1);
                        state_next = S_CHECK;
                    end
                    default:
                    begin
                        pos_next   = pos_reg + PW'(1);
                        state_next = S_CHECK;
                    end
                endcase
            end
            S_CONT:
            begin
                if (need_reg == 2'd1)
                begin
                    if (cmp_match)
                    begin
                        idx_next   = glyph_reg;
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        pos_next   = rp_reg + PW'(1);
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    val_next  = cont_val;
                    need_next = need_reg - 2'd1;
                    rp_next   = rp_reg + PW'(1);
                end
            end
            S_RESOLVE:
            begin
                if (want_fallback)
                begin
                    code_next  = FALLBACK_CODE;
                    state_next = S_START;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        pos_reg   <= pos_next;
        glyph_reg <= glyph_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        need_reg  <= need_next;
    end

    assign rd_addr   = rp_next[AW-1:0];
    assign res.done  = (state_reg == S_RESOLVE) && !want_fallback;
    assign res.index = idx_reg;

endmodule

### src/font_glyph_lookup.sv
// top level of the font glyph lookup block
//
// Input beats carry op, table_byte and code_point. A clear beat empties the
// unicode table and an append beat adds one byte while the table has room;
// neither gives a result. A lookup beat gives exactly one result beat with
// found_valid, glyph_number and glyph_address.
// A lookup walks the table in the byte store, one byte per cycle with a
// bounds check state before each entry, and walks it again when the lookup
// repeats for the replacement character. The scan sequencer and the single
// read port of the byte store set this pace. With the table disabled the scan
// skips the walk, and with the font invalid the lookup skips the scan. in_stall
// is high while a lookup is at work.
// The result sits in an output register; a new beat is taken while it waits,
// and a finished lookup holds in its last step until out_stall lets the old
// result go. Configuration writes are always ready and are meant for idle.
// Reset empties the table, idles both FSMs, zeroes config and drops out_valid.
module font_glyph_lookup #(
    parameter int TABLE_BYTES = 16384
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        op,
    input  logic [7:0]                        table_byte,
    input  logic [fgl_pkg::CODE_W-1:0]        code_point,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found_valid,
    output logic [fgl_pkg::GLYPH_W-1:0]       glyph_number,
    output logic [fgl_pkg::ADDR_W-1:0]        glyph_address,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fgl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    import fgl_pkg::*;

    localparam int AW = $clog2(TABLE_BYTES);
    localparam int LW = $clog2(TABLE_BYTES + 1);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_SCAN = 4'b0010,
        T_MUL  = 4'b0100,
        T_OUT  = 4'b1000
    } top_state_t;

    top_state_t           state_reg, state_next;
    logic                 font_valid_reg;
    logic                 table_enabled_reg;
    logic [GLYPH_W-1:0]   glyph_count_reg;
    logic [GBYTES_W-1:0]  glyph_bytes_reg;
    logic [ADDR_W-1:0]    glyph_base_reg;
    logic [GLYPH_W-1:0]   idx_reg, idx_next;
    logic [PROD_W-1:0]    prod_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg;
    logic [GLYPH_W-1:0]   number_reg;
    logic [ADDR_W-1:0]    address_reg;

    logic                 in_accept;
    logic                 cfg_write;
    logic                 out_free;
    logic                 load_out;
    logic                 scan_start;
    logic                 tbl_clear;
    logic                 tbl_append;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           rd_data;
    logic [LW-1:0]        map_length;
    scan_cfg_t            scan_cfg;
    scan_res_t            scan_res;

    assign in_stall   = (state_reg != T_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || !out_stall;
    assign load_out   = (state_reg == T_OUT) && out_free;
    assign tbl_clear  = in_accept && (op_t'(op) == OP_CLEAR);
    assign tbl_append = in_accept && (op_t'(op) == OP_APPEND);
    assign scan_start = in_accept && (op_t'(op) == OP_LOOKUP) && font_valid_reg;

    assign scan_cfg.table_enabled = table_enabled_reg;
    assign scan_cfg.glyph_count   = glyph_count_reg;

    fgl_table_ram #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_table_ram (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (tbl_clear),
        .append     (tbl_append),
        .wr_byte    (table_byte),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .map_length (map_length)
    );

    fgl_scan #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .code       (code_point),
        .cfg        (scan_cfg),
        .map_length (map_length),
        .rd_data    (rd_data),
        .rd_addr    (rd_addr),
        .res        (scan_res)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_accept && (op_t'(op) == OP_LOOKUP))
                begin
                    if (font_valid_reg)
                    begin
                        state_next = T_SCAN;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = T_MUL;
                    end
                end
            end
            T_SCAN:
            begin
                if (scan_res.done)
                begin
                    idx_next   = scan_res.index;
                    state_next = T_MUL;
                end
            end
            T_MUL:
            begin
                state_next = T_OUT;
            end
            T_OUT:
            begin
                if (out_free)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            out_valid_reg     <= 1'b0;
            font_valid_reg    <= 1'b0;
            table_enabled_reg <= 1'b0;
            glyph_count_reg   <= '0;
            glyph_bytes_reg   <= '0;
            glyph_base_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_FONT_VALID:    font_valid_reg    <= cfg_data[0];
                    CFG_TABLE_ENABLED: table_enabled_reg <= cfg_data[0];
                    CFG_GLYPH_COUNT:   glyph_count_reg   <= cfg_data[GLYPH_W-1:0];
                    CFG_GLYPH_BYTES:   glyph_bytes_reg   <= cfg_data[GBYTES_W-1:0];
                    CFG_GLYPH_BASE:    glyph_base_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (state_reg == T_MUL)
        begin
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(glyph_bytes_reg);
        end
        if (load_out)
        begin
            found_reg   <= font_valid_reg;
            number_reg  <= idx_reg;
            address_reg <= font_valid_reg ? (glyph_base_reg + ADDR_W'(prod_reg)) : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found_valid   = found_reg;
    assign glyph_number  = number_reg;
    assign glyph_address = address_reg;

endmodule

### src/fgl_checker.sv
// port-level checks for the font glyph lookup block and their bind
module fgl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  op,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        found_valid,
    input logic [fgl_pkg::GLYPH_W-1:0] glyph_number,
    input logic [fgl_pkg::ADDR_W-1:0]  glyph_address
);

    import fgl_pkg::*;

    // a lookup beat keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_LOOKUP) |=> in_stall)
        else $error("lookup accepted but block ready next cycle");

    // a new result only appears after the block was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat without a lookup in progress");

    // null result carries zero index and address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found_valid |-> (glyph_number == '0) && (glyph_address == '0))
        else $error("null result with nonzero payload");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(glyph_number)
            && $stable(glyph_address) && $stable(found_valid))
        else $error("stalled result beat changed");

endmodule

bind font_glyph_lookup fgl_checker u_fgl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found_valid   (found_valid),
    .glyph_number  (glyph_number),
    .glyph_address (glyph_address)
);
